@@ rtl/core/sic_pkg.sv @@
// Package for the streaming inversion counter: default widths and shared constants.
// Used by sic_level_cell, streaming_inversion_counter and the testbench; depends on nothing.
`timescale 1ns / 1ps

package sic_pkg;

	// Default value domain width and per-node count width.
	localparam int unsigned VALUE_BITS_DEF = 10;
	localparam int unsigned COUNT_BITS_DEF = 16;

	// Width of the running inversion total.
	localparam int unsigned TOTAL_BITS = 32;

endpackage

@@ rtl/core/sic_level_cell.sv @@
// One tree level of the streaming inversion counter: a row memory of node-count pairs.
// Depends on sic_pkg; instantiated once per level by streaming_inversion_counter.
`timescale 1ns / 1ps

module sic_level_cell import sic_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
	parameter int unsigned LEVEL      = 1,
	localparam int unsigned CLR_W     = (VALUE_BITS > 1) ? VALUE_BITS - 1 : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [VALUE_BITS-1:0] rd_value,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  clr_en,
	input  logic [CLR_W-1:0]      clr_addr,
	input  logic                  tok_in_valid,
	input  logic [COUNT_BITS-1:0] tok_in_sum,
	output logic                  tok_out_valid,
	output logic [COUNT_BITS-1:0] tok_out_sum
);

	// Each row holds the two children of one node of the level above: {right, left}.
	localparam int unsigned ROWS  = 1 << (LEVEL - 1);
	localparam int unsigned ROW_W = (LEVEL > 1) ? LEVEL - 1 : 1;

	logic [2*COUNT_BITS-1:0] mem [ROWS];
	logic [2*COUNT_BITS-1:0] rdata_q;
	logic                    tok_valid_q;
	logic [COUNT_BITS-1:0]   tok_sum_q;

	logic [ROW_W-1:0]        rd_row;
	logic [ROW_W-1:0]        path_row;
	logic [ROW_W-1:0]        clr_row;
	logic [ROW_W-1:0]        wr_row;
	logic                    wr_en;
	logic [2*COUNT_BITS-1:0] wr_data;
	logic                    path_bit;
	logic [COUNT_BITS-1:0]   left_cnt;
	logic [COUNT_BITS-1:0]   right_cnt;
	logic [COUNT_BITS:0]     sum_wide;
	logic [COUNT_BITS-1:0]   sum_next;

	generate
		if (LEVEL > 1) begin : g_prefix
			assign rd_row   = rd_value[VALUE_BITS-1 -: LEVEL-1];
			assign path_row = value[VALUE_BITS-1 -: LEVEL-1];
			assign clr_row  = clr_addr[ROW_W-1:0];
		end else begin : g_top
			assign rd_row   = '0;
			assign path_row = '0;
			assign clr_row  = '0;
		end
	endgenerate

	assign path_bit  = value[VALUE_BITS-LEVEL];
	assign left_cnt  = rdata_q[COUNT_BITS-1:0];
	assign right_cnt = rdata_q[2*COUNT_BITS-1:COUNT_BITS];

	// Going left adds the right sibling to the query; the sum saturates.
	always_comb begin
		sum_wide = {1'b0, tok_in_sum} + {1'b0, right_cnt};
		if (path_bit) begin
			sum_next = tok_in_sum;
		end else if (sum_wide[COUNT_BITS]) begin
			sum_next = '1;
		end else begin
			sum_next = sum_wide[COUNT_BITS-1:0];
		end
	end

	// Saturating increment of the child on the path, or zero for a row being cleared.
	always_comb begin
		wr_data = rdata_q;
		if (clr_en) begin
			wr_data = '0;
		end else if (path_bit) begin
			if (right_cnt != '1) begin
				wr_data[2*COUNT_BITS-1:COUNT_BITS] = right_cnt + 1'b1;
			end
		end else begin
			if (left_cnt != '1) begin
				wr_data[COUNT_BITS-1:0] = left_cnt + 1'b1;
			end
		end
	end

	assign wr_en  = clr_en | tok_in_valid;
	assign wr_row = clr_en ? clr_row : path_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in_valid) begin
			tok_sum_q <= sum_next;
		end
	end

	assign tok_out_valid = tok_valid_q;
	assign tok_out_sum   = tok_sum_q;

endmodule

@@ rtl/core/streaming_inversion_counter.sv @@
// Top level of the streaming inversion counter: level cell chain, clear sweep, result stage.
// Depends on sic_pkg and sic_level_cell.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+----------------------------------
// sample   | in        | sample_valid / sample_ready | sample_value
// result   | out       | result_valid / result_ready | added_inversions, running_total
//
// One transaction in gives one transaction out: every level reads its row at the accepting
// edge, then the partial count passes down the cell chain through one register per tree
// level, and the total and the output or hold register are updated together at its end.
// A new sample is taken once the previous result has moved into the output register, so
// only one item is in flight at a time.
// After reset a clearing sweep writes zero to every row of every level; sample_ready
// stays low until it ends.
// A stalled result waits in the output register and a second one in a hold register;
// sample_ready stays low until the hold register drains.

module streaming_inversion_counter import sic_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  logic [VALUE_BITS-1:0] sample_value,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [COUNT_BITS-1:0] added_inversions,
	output logic [TOTAL_BITS-1:0] running_total
);

	localparam int unsigned CLR_W = (VALUE_BITS > 1) ? VALUE_BITS - 1 : 1;

	// The tree is heap shaped over the value domain. Level L (1 .. VALUE_BITS) lives in one
	// cell, stored as rows of left/right child pairs. The root count is never read by a
	// query, so it is not kept.

	logic                  busy_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  start_valid_q;
	logic [TOTAL_BITS-1:0] total_q;

	logic                  clr_busy_q;
	logic [CLR_W-1:0]      clr_addr_q;

	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_added_q;
	logic [TOTAL_BITS-1:0] out_total_q;
	logic                  hold_valid_q;
	logic [COUNT_BITS-1:0] hold_added_q;
	logic [TOTAL_BITS-1:0] hold_total_q;

	logic                  accept;
	logic                  tok_valid [VALUE_BITS+1];
	logic [COUNT_BITS-1:0] tok_sum   [VALUE_BITS+1];
	logic                  fin_valid;
	logic [COUNT_BITS-1:0] fin_sum;
	logic [TOTAL_BITS:0]   total_wide;
	logic [TOTAL_BITS-1:0] total_next;
	logic                  out_free;
	logic                  load_from_hold;
	logic                  load_from_fin;
	logic                  load_hold;

	assign sample_ready = !busy_q && !clr_busy_q;
	assign accept       = sample_valid && sample_ready;

	// The chain starts with an empty partial count in the cycle after acceptance, when every
	// cell already has its row read back.
	assign tok_valid[0] = start_valid_q;
	assign tok_sum[0]   = '0;

	genvar lv;
	generate
		for (lv = 1; lv <= VALUE_BITS; lv++) begin : g_level
			sic_level_cell #(
				.VALUE_BITS (VALUE_BITS),
				.COUNT_BITS (COUNT_BITS),
				.LEVEL      (lv)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.rd_en         (accept),
				.rd_value      (sample_value),
				.value         (value_q),
				.clr_en        (clr_busy_q),
				.clr_addr      (clr_addr_q),
				.tok_in_valid  (tok_valid[lv-1]),
				.tok_in_sum    (tok_sum[lv-1]),
				.tok_out_valid (tok_valid[lv]),
				.tok_out_sum   (tok_sum[lv])
			);
		end
	endgenerate

	assign fin_valid = tok_valid[VALUE_BITS];
	assign fin_sum   = tok_sum[VALUE_BITS];

	// Running total saturates at its maximum.
	always_comb begin
		total_wide = {1'b0, total_q} + {{(TOTAL_BITS + 1 - COUNT_BITS){1'b0}}, fin_sum};
		total_next = total_wide[TOTAL_BITS] ? '1 : total_wide[TOTAL_BITS-1:0];
	end

	// A finished item goes to the output register when it is free, otherwise it parks in
	// the hold register; the hold register drains first.
	assign out_free       = !out_valid_q || result_ready;
	assign load_from_hold = hold_valid_q && out_free;
	assign load_from_fin  = fin_valid && out_free && !hold_valid_q;
	assign load_hold      = fin_valid && !load_from_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			start_valid_q <= 1'b0;
			total_q       <= '0;
			clr_busy_q    <= 1'b1;
			clr_addr_q    <= '0;
			out_valid_q   <= 1'b0;
			hold_valid_q  <= 1'b0;
		end else begin
			start_valid_q <= accept;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (fin_valid) begin
				total_q <= total_next;
			end
			priority if (accept) begin
				busy_q <= 1'b1;
			end else if (load_from_hold || load_from_fin) begin
				busy_q <= 1'b0;
			end
			if (load_from_hold) begin
				hold_valid_q <= 1'b0;
			end else if (load_hold) begin
				hold_valid_q <= 1'b1;
			end
			priority if (load_from_hold || load_from_fin) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= sample_value;
		end
		if (load_hold) begin
			hold_added_q <= fin_sum;
			hold_total_q <= total_next;
		end
		if (load_from_hold) begin
			out_added_q <= hold_added_q;
			out_total_q <= hold_total_q;
		end else if (load_from_fin) begin
			out_added_q <= fin_sum;
			out_total_q <= total_next;
		end
	end

	assign result_valid     = out_valid_q;
	assign added_inversions = out_added_q;
	assign running_total    = out_total_q;

	// A finished count only comes out of the chain while an item is in flight.
	a_fin_while_busy : assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid |-> busy_q)
		else $error("cell chain produced a result with no item in flight");

	// A finished count never finds the hold register occupied.
	a_hold_free : assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid |-> !hold_valid_q)
		else $error("result arrived while hold register was full");

	// The inversion total never decreases.
	a_total_monotonic : assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> total_q >= $past(total_q))
		else $error("inversion total decreased");

	// No item enters while the tree store is being cleared.
	a_no_walk_in_clear : assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !start_valid_q && !busy_q)
		else $error("item in flight during clearing sweep");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for streaming_inversion_counter at its default widths.
// Holds its own tree-count predictor and drives both handshakes with random idling.
// Depends on sic_pkg and the streaming_inversion_counter RTL.
`timescale 1ns / 1ps

module testbench;
	import sic_pkg::*;

	localparam int unsigned VALUE_BITS   = VALUE_BITS_DEF;
	localparam int unsigned COUNT_BITS   = COUNT_BITS_DEF;
	localparam int unsigned MAX_VALUE    = (1 << VALUE_BITS) - 1;
	localparam int unsigned NODE_COUNT   = (1 << (VALUE_BITS + 1)) - 1;
	localparam int unsigned DRAIN_CYCLES = VALUE_BITS + 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_BITS) - 1;

	typedef struct packed {
		logic [COUNT_BITS-1:0] added;
		logic [TOTAL_BITS-1:0] total;
	} inversion_result_t;

	logic                  clk;
	logic                  arst_n           = 1'b0;
	logic                  sample_valid     = 1'b0;
	logic                  sample_ready;
	logic [VALUE_BITS-1:0] sample_value     = '0;
	logic                  result_valid;
	logic                  result_ready     = 1'b0;
	logic [COUNT_BITS-1:0] added_inversions;
	logic [TOTAL_BITS-1:0] running_total;

	// Predictor state: one saturating count per heap-indexed tree node and the running total.
	logic [COUNT_BITS-1:0] tree_count [1:NODE_COUNT] = '{default: '0};
	logic [TOTAL_BITS-1:0] total_inversions = '0;

	inversion_result_t     pending_results [$];
	logic [VALUE_BITS-1:0] last_sample      = '0;
	int unsigned           error_count      = 0;
	int unsigned           cycle_count      = 0;
	int unsigned           send_idle_pct    = 0;
	int unsigned           recv_stall_pct   = 0;
	int unsigned           hold_request     = 0;

	streaming_inversion_counter #(
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_ready    (sample_ready),
		.sample_value    (sample_value),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.added_inversions(added_inversions),
		.running_total   (running_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Counts the earlier values strictly greater than v by summing the right
	// siblings along the root-to-leaf path, then records v on that path.
	function automatic inversion_result_t predict_inversions(input logic [VALUE_BITS-1:0] v);
		int unsigned       node;
		int                d;
		longint unsigned   acc;
		longint unsigned   sum;
		inversion_result_t r;
		node = 1;
		acc = 0;
		for (d = VALUE_BITS - 1; d >= 0; d--) begin
			if (!v[d]) begin
				acc += tree_count[2 * node + 1];
			end
			node = 2 * node + v[d];
		end
		if (acc > COUNT_MAX) begin
			acc = COUNT_MAX;
		end
		node = 1;
		for (d = VALUE_BITS; d >= 0; d--) begin
			if (tree_count[node] != COUNT_MAX) begin
				tree_count[node] = tree_count[node] + 1'b1;
			end
			if (d > 0) begin
				node = 2 * node + v[d-1];
			end
		end
		sum = longint'(total_inversions) + acc;
		if (sum > TOTAL_MAX) begin
			sum = TOTAL_MAX;
		end
		total_inversions = sum[TOTAL_BITS-1:0];
		r.added = acc[COUNT_BITS-1:0];
		r.total = total_inversions;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endtask

	// Offers one sample, with random idle cycles first, and records the expected
	// result once the transaction is accepted. Valid is left high on return so that
	// a following call can keep it up without a low pulse.
	task automatic send_sample(input logic [VALUE_BITS-1:0] v);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_value <= v;
		do begin
			@(posedge clk);
		end while (!sample_ready);
		pending_results.push_back(predict_inversions(v));
		last_sample = v;
	endtask

	// Sender goes quiet until every expected result has come back, then lets the
	// pipeline settle.
	task automatic wait_for_drain();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Uniform values half the time, plus clusters, repeats and power-of-two boundaries so that
	// duplicates and neighbors meet often in the tree.
	function automatic logic [VALUE_BITS-1:0] pick_sample();
		int unsigned kind;
		int unsigned k;
		int          v;
		kind = $urandom_range(99);
		if (kind < 50) begin
			v = $urandom_range(MAX_VALUE);
		end else if (kind < 70) begin
			v = int'($urandom_range(MAX_VALUE)) + int'($urandom_range(16)) - 8;
			if (v < 0) v = 0;
			if (v > int'(MAX_VALUE)) v = MAX_VALUE;
		end else if (kind < 85) begin
			v = last_sample;
		end else begin
			k = $urandom_range(VALUE_BITS - 1);
			case ($urandom_range(3))
				0: v = 0;
				1: v = MAX_VALUE;
				2: v = 1 << k;
				default: v = (1 << k) - 1;
			endcase
		end
		return VALUE_BITS'(v);
	endfunction

	task automatic test_corner_values();
		int unsigned corners [20] = '{0, 1023, 1023, 0, 512, 511, 1, 1022, 341, 682,
			1000, 900, 800, 700, 600, 600, 2, 3, 1023, 0};
		int i;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (i = 0; i < 20; i++) begin
			send_sample(corners[i][VALUE_BITS-1:0]);
		end
		wait_for_drain();
	endtask

	task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned count);
		int unsigned i;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (i = 0; i < count; i++) begin
			send_sample(pick_sample());
		end
		wait_for_drain();
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 0, 150);
		run_random_phase(64, 0, 150);
		run_random_phase(0, 64, 150);
		run_random_phase(36, 36, 150);
	endtask

	// The receiver holds off long enough for the output and hold registers to fill,
	// so the block must drop sample_ready while the sender keeps offering.
	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 300;
		for (i = 0; i < 30; i++) begin
			send_sample(pick_sample());
		end
		wait_for_drain();
	endtask

	// A run of the top value piles up counts along the rightmost path; the values that
	// follow must then pick up that whole run as inversions, including the smallest value.
	task automatic test_repeated_top_value();
		int unsigned tail [8] = '{0, 1022, 1022, 0, 1021, 511, 768, 0};
		int unsigned i;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (i = 0; i < 40; i++) begin
			send_sample(MAX_VALUE[VALUE_BITS-1:0]);
		end
		send_idle_pct = 36;
		recv_stall_pct = 36;
		for (i = 0; i < 8; i++) begin
			send_sample(tail[i][VALUE_BITS-1:0]);
		end
		wait_for_drain();
	endtask

	// Result side: ready follows the stall rate, except during a requested hold-off
	// that this process counts down by itself.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Every accepted result transaction is matched against the oldest expectation.
	initial begin
		inversion_result_t exp;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					flag_error($sformatf("unexpected result: added=%0d total=%0d",
						added_inversions, running_total));
				end else begin
					exp = pending_results.pop_front();
					if (added_inversions !== exp.added) begin
						flag_error($sformatf("added_inversions: expected %0d, got %0d",
							exp.added, added_inversions));
					end
					if (running_total !== exp.total) begin
						flag_error($sformatf("running_total: expected %0d, got %0d",
							exp.total, running_total));
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_corner_values();
		test_random_traffic();
		test_backpressure();
		test_repeated_top_value();
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/sic_pkg.sv
rtl/core/sic_level_cell.sv
rtl/core/streaming_inversion_counter.sv
tb/testbench.sv
